### hw/rtl/bcpa_pkg.sv
package bcpa_pkg;

  localparam int unsigned HEAP_PAGES = 1024;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned STATUS_W   = 2;

  localparam int unsigned WORD_BITS = 16;
  localparam int unsigned WORD_SH   = $clog2(WORD_BITS);
  localparam int unsigned ROWS      = HEAP_PAGES / WORD_BITS;
  localparam int unsigned ROW_W     = $clog2(ROWS);
  localparam int unsigned PAGE_W    = $clog2(HEAP_PAGES);
  localparam int unsigned LEN_W     = $clog2(HEAP_PAGES + WORD_BITS + 1);
  localparam int unsigned CMP_W     = (LEN_W > CNT_W) ? LEN_W : CNT_W;

  localparam longint unsigned WIN_SPAN = longint'(HEAP_PAGES) << PAGE_SHIFT;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } bcpa_op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_NO_SPACE = 2'd2
  } bcpa_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_MARK_RD,
    S_MARK_WR,
    S_RESP
  } bcpa_state_e;

  typedef struct packed {
    logic         load;
    logic         scan_init;
    logic         scan_step;
    logic         mark_init_free;
    logic         mark_init_alloc;
    logic         mark_rd;
    logic         mark_wr;
    logic         out_load;
    bcpa_status_e out_code;
  } bcpa_cmd_t;

  typedef struct packed {
    bcpa_op_e     op;
    logic         chk_fail;
    bcpa_status_e chk_code;
    logic         hit;
    logic         miss;
    logic         mark_done;
  } bcpa_flags_t;

endpackage

### hw/rtl/bcpa_dp.sv
module bcpa_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bcpa_pkg::ADDR_W-1:0]   cfg_wdata_i,
  input  logic                          opcode_i,
  input  logic [bcpa_pkg::CNT_W-1:0]    page_count_i,
  input  logic [bcpa_pkg::ADDR_W-1:0]   free_address_i,
  input  bcpa_pkg::bcpa_cmd_t           cmd_i,
  output bcpa_pkg::bcpa_flags_t         flags_o,
  output logic [bcpa_pkg::ADDR_W-1:0]   run_address_o,
  output logic [bcpa_pkg::STATUS_W-1:0] status_o
);
  import bcpa_pkg::*;

  logic [ADDR_W-1:0]    heap_base_q;
  bcpa_op_e             op_q;
  logic [CNT_W-1:0]     count_q;
  logic [ADDR_W-1:0]    addr_q;

  logic [WORD_BITS-1:0] mem [ROWS];
  logic [ROWS-1:0]      row_valid_q;
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 rd_vld_q;
  logic                 rd_en;
  logic [ROW_W-1:0]     rd_addr;

  logic [ROW_W:0]       scan_ptr_q;
  logic                 scan_more;
  logic                 eval_v_q;
  logic [ROW_W-1:0]     eval_row_q;
  logic [CMP_W-1:0]     run_q;

  logic [PAGE_W-1:0]    mark_first_q;
  logic [PAGE_W-1:0]    mark_last_q;
  logic [ROW_W-1:0]     mrow_q;

  logic [ADDR_W-1:0]    run_address_q;
  logic [STATUS_W-1:0]  status_q;

  logic [ADDR_W-1:0]    win_start;
  logic [ADDR_W:0]      win_end;
  logic [ADDR_W-1:0]    off;
  logic [PAGE_W-1:0]    free_first;
  logic [CMP_W:0]       free_end;
  logic [CMP_W:0]       free_last_w;
  logic [PAGE_W-1:0]    free_last;
  logic [CMP_W-1:0]     count_cmp;
  logic                 count_zero;
  logic                 count_big;
  logic                 in_window;
  logic                 aligned;
  logic                 fits;

  logic [WORD_BITS-1:0] eff_row;
  logic [WORD_BITS-1:0] zero_seen;
  logic [WORD_SH-1:0]   zpos [WORD_BITS];
  logic [CMP_W-1:0]     len [WORD_BITS];
  logic [WORD_BITS-1:0] hit_vec;
  logic                 found;
  logic [WORD_SH-1:0]   hit_j;
  logic [PAGE_W-1:0]    hit_end;
  logic [CMP_W-1:0]     hit_first_w;
  logic [PAGE_W-1:0]    hit_first;

  logic [WORD_BITS-1:0] mark_mask;
  logic [WORD_BITS-1:0] new_row;
  logic [ADDR_W-1:0]    alloc_addr;

  assign win_start   = {heap_base_q[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
  assign win_end     = {1'b0, win_start} + (ADDR_W + 1)'(WIN_SPAN);
  assign off         = addr_q - win_start;
  assign free_first  = off[PAGE_SHIFT +: PAGE_W];
  assign count_cmp   = CMP_W'(count_q);
  assign free_end    = (CMP_W + 1)'(free_first) + (CMP_W + 1)'(count_q);
  assign free_last_w = free_end - (CMP_W + 1)'(1);
  assign free_last   = free_last_w[PAGE_W-1:0];
  assign count_zero  = (count_q == '0);
  assign count_big   = (count_cmp > CMP_W'(HEAP_PAGES));
  assign in_window   = (addr_q >= win_start) && ({1'b0, addr_q} < win_end);
  assign aligned     = (addr_q[PAGE_SHIFT-1:0] == '0);
  assign fits        = (free_end <= (CMP_W + 1)'(HEAP_PAGES));

  always_comb begin
    flags_o.op        = op_q;
    flags_o.hit       = eval_v_q && found;
    flags_o.miss      = eval_v_q && !found && (eval_row_q == ROW_W'(ROWS - 1));
    flags_o.mark_done = (mrow_q == mark_last_q[PAGE_W-1:WORD_SH]);
    if (op_q == OP_ALLOC) begin
      flags_o.chk_fail = count_zero || count_big;
      flags_o.chk_code = count_zero ? STATUS_INVALID : STATUS_NO_SPACE;
    end else begin
      flags_o.chk_fail = count_zero || !in_window || !aligned || !fits;
      flags_o.chk_code = STATUS_INVALID;
    end
  end

  // A row that was never written reads as its reset value, all pages free.
  assign eff_row = rd_vld_q ? rd_data_q : '1;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      zero_seen[j] = 1'b0;
      zpos[j]      = '0;
      for (int k = 0; k <= j; k++) begin
        if (!eff_row[k]) begin
          zero_seen[j] = 1'b1;
          zpos[j]      = WORD_SH'(k);
        end
      end
      if (!eff_row[j]) begin
        len[j] = '0;
      end else if (!zero_seen[j]) begin
        len[j] = run_q + CMP_W'(j + 1);
      end else begin
        len[j] = CMP_W'(j) - CMP_W'(zpos[j]);
      end
      hit_vec[j] = (len[j] >= count_cmp);
    end
  end

  always_comb begin
    hit_j = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (hit_vec[j]) begin
        hit_j = WORD_SH'(j);
      end
    end
  end

  assign found       = |hit_vec;
  assign hit_end     = {eval_row_q, hit_j};
  assign hit_first_w = CMP_W'(hit_end) + CMP_W'(1) - count_cmp;
  assign hit_first   = hit_first_w[PAGE_W-1:0];

  always_comb begin
    logic [PAGE_W-1:0] idx;
    for (int b = 0; b < WORD_BITS; b++) begin
      idx          = {mrow_q, WORD_SH'(b)};
      mark_mask[b] = (idx >= mark_first_q) && (idx <= mark_last_q);
    end
  end

  assign new_row    = (op_q == OP_FREE) ? (eff_row | mark_mask) : (eff_row & ~mark_mask);
  assign alloc_addr = win_start + ADDR_W'({mark_first_q, {PAGE_SHIFT{1'b0}}});

  assign scan_more = (scan_ptr_q != (ROW_W + 1)'(ROWS));
  assign rd_en     = (cmd_i.scan_step && scan_more) || cmd_i.mark_rd;
  assign rd_addr   = cmd_i.mark_rd ? mrow_q : scan_ptr_q[ROW_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= '0;
      row_valid_q <= '0;
      eval_v_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        heap_base_q <= cfg_wdata_i;
      end
      if (cmd_i.mark_wr) begin
        row_valid_q[mrow_q] <= 1'b1;
      end
      if (cmd_i.scan_init) begin
        eval_v_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        eval_v_q <= scan_more;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mark_wr) begin
      mem[mrow_q] <= new_row;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
      rd_vld_q  <= row_valid_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= bcpa_op_e'(opcode_i);
      count_q <= page_count_i;
      addr_q  <= free_address_i;
    end
    if (cmd_i.scan_init) begin
      scan_ptr_q <= '0;
      run_q      <= '0;
    end else if (cmd_i.scan_step) begin
      if (scan_more) begin
        scan_ptr_q <= scan_ptr_q + (ROW_W + 1)'(1);
        eval_row_q <= scan_ptr_q[ROW_W-1:0];
      end
      if (eval_v_q) begin
        run_q <= len[WORD_BITS-1];
      end
    end
    if (cmd_i.mark_init_free) begin
      mark_first_q <= free_first;
      mark_last_q  <= free_last;
      mrow_q       <= free_first[PAGE_W-1:WORD_SH];
    end else if (cmd_i.mark_init_alloc) begin
      mark_first_q <= hit_first;
      mark_last_q  <= hit_end;
      mrow_q       <= hit_first[PAGE_W-1:WORD_SH];
    end else if (cmd_i.mark_wr) begin
      mrow_q <= mrow_q + ROW_W'(1);
    end
    if (cmd_i.out_load) begin
      status_q      <= cmd_i.out_code;
      run_address_q <= ((cmd_i.out_code == STATUS_OK) && (op_q == OP_ALLOC)) ? alloc_addr : '0;
    end
  end

  assign run_address_o = run_address_q;
  assign status_o      = status_q;

  a_run_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan_step && eval_v_q) |-> (run_q < count_cmp))
    else $error("free run carried into a row already reaches the request");

  a_mark_row_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mark_wr |-> (mrow_q >= mark_first_q[PAGE_W-1:WORD_SH]) &&
                      (mrow_q <= mark_last_q[PAGE_W-1:WORD_SH]))
    else $error("map row written outside the run being marked");

  a_run_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mark_rd |-> (mark_first_q <= mark_last_q))
    else $error("run bounds out of order");

endmodule

### hw/rtl/bcpa_ctrl.sv
module bcpa_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  bcpa_pkg::bcpa_flags_t flags_i,
  output bcpa_pkg::bcpa_cmd_t   cmd_o
);
  import bcpa_pkg::*;

  bcpa_state_e  state_q, state_d;
  bcpa_status_e code_q, code_d;
  logic         out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (flags_i.chk_fail) begin
          code_d  = flags_i.chk_code;
          state_d = S_RESP;
        end else if (flags_i.op == OP_ALLOC) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_MARK_RD;
        end
      end
      S_SCAN: begin
        if (flags_i.hit) begin
          state_d = S_MARK_RD;
        end else if (flags_i.miss) begin
          code_d  = STATUS_NO_SPACE;
          state_d = S_RESP;
        end
      end
      S_MARK_RD: begin
        state_d = S_MARK_WR;
      end
      S_MARK_WR: begin
        if (flags_i.mark_done) begin
          code_d  = STATUS_OK;
          state_d = S_RESP;
        end else begin
          state_d = S_MARK_RD;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.out_code = code_q;
    in_ready_o     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_CHECK: begin
        if (!flags_i.chk_fail) begin
          cmd_o.scan_init      = (flags_i.op == OP_ALLOC);
          cmd_o.mark_init_free = (flags_i.op == OP_FREE);
        end
      end
      S_SCAN: begin
        cmd_o.scan_step       = 1'b1;
        cmd_o.mark_init_alloc = flags_i.hit;
      end
      S_MARK_RD: begin
        cmd_o.mark_rd = 1'b1;
      end
      S_MARK_WR: begin
        cmd_o.mark_wr = 1'b1;
      end
      S_RESP: begin
        cmd_o.out_load = !out_valid_q || out_ready_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      code_q      <= STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      code_q      <= code_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_CHECK))
    else $error("accepted request did not enter the check step");

  a_load_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (out_valid_q && (state_q == S_IDLE)))
    else $error("response load did not present a result and return to idle");

endmodule

### hw/rtl/bitmap_contiguous_page_allocator.sv
// Bitmap first-fit allocator of contiguous pages in a window of virtual pages.
// The request channel (in_valid_i/in_ready_o) carries opcode_i, page_count_i and
// free_address_i; each request yields exactly one transfer on the result channel
// (out_valid_o/out_ready_i) with run_address_o and status_o.
// The user must write heap_base through cfg_we_i/cfg_wdata_i only while no
// request is pending; the block does not enforce this. The free map is kept as
// rows of 16 pages in a single-port memory. Each request starts with a check;
// an allocate then scans one row per cycle from the bottom, and both allocate
// and free read and rewrite each row of the run; the result register is loaded
// last. A failed check goes straight to it. Only one request is in flight.
// Reset marks every page free through per-row valid bits, so no clearing pass
// follows it, and sets heap_base to zero. The result register lets a new request
// be taken while a result waits; a stalled receiver holds the next result back.
module bitmap_contiguous_page_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bcpa_pkg::ADDR_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [bcpa_pkg::CNT_W-1:0]    page_count_i,
  input  logic [bcpa_pkg::ADDR_W-1:0]   free_address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bcpa_pkg::ADDR_W-1:0]   run_address_o,
  output logic [bcpa_pkg::STATUS_W-1:0] status_o
);
  import bcpa_pkg::*;

  bcpa_cmd_t   cmd;
  bcpa_flags_t flags;

  bcpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .flags_i     (flags),
    .cmd_o       (cmd)
  );

  bcpa_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .opcode_i       (opcode_i),
    .page_count_i   (page_count_i),
    .free_address_i (free_address_i),
    .cmd_i          (cmd),
    .flags_o        (flags),
    .run_address_o  (run_address_o),
    .status_o       (status_o)
  );

endmodule
